/* hw/rtl/xsc_pkg.sv */
`default_nettype none

package xsc_pkg;

  // fixed sizes
  localparam int NONCE_BYTES       = 12;
  localparam int KEY_BYTES_DEFAULT = 32;
  localparam int TAG_BYTES_DEFAULT = 16;
  localparam int IDX_W             = 5;

  // hash seeds and multipliers
  localparam logic [31:0] HA_INIT   = 32'h811C9DC5;
  localparam logic [31:0] HB_INIT   = 32'h9E3779B9;
  localparam logic [31:0] MUL_A     = 32'h01000193;
  localparam logic [31:0] MUL_MSG   = 32'h85EBCA6B;
  localparam logic [31:0] MUL_NONCE = 32'hC2B2AE35;
  localparam logic [31:0] MUL_KEY   = 32'h27D4EB2F;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE       = 3'd0;
  localparam logic [2:0] CFG_KEY_COUNT  = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD0  = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD1  = 3'd3;
  localparam logic [2:0] CFG_KEY_WORD2  = 3'd4;
  localparam logic [2:0] CFG_KEY_WORD3  = 3'd5;
  localparam logic [2:0] CFG_NONCE_LOW  = 3'd6;
  localparam logic [2:0] CFG_NONCE_HIGH = 3'd7;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MSG,
    OP_NONCE,
    OP_KEY,
    OP_TAG
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [2:0]       rot;
    logic             final_tag;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic key_done;
  } stat_t;

  // rotate a byte left by s
  function automatic logic [7:0] rot8(input logic [7:0] v, input logic [2:0] s);
    logic [15:0] t;
    t = {v, v} << s;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/xor_stream_cipher_with_tag_unit.sv */
// Each data byte is latched by the load step, then ciphered into the output register by the
// message step, which waits while the output is stalled; in_stall holds off the next byte until the unit is idle again.
// On a last byte the hash unit absorbs 12 nonce bytes and the effective key bytes, one per
// cycle, then emits TAG_BYTES tag bytes, one per cycle while the output is not stalled.
// Reset (rst, synchronous) clears configuration to defaults, reloads hashes and positions.
`default_nettype none

module xor_stream_cipher_with_tag_unit #(
  parameter int KEY_BYTES = xsc_pkg::KEY_BYTES_DEFAULT,
  parameter int TAG_BYTES = xsc_pkg::TAG_BYTES_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  data_byte,
  input  wire         last_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [7:0]  out_byte,
  output logic        is_tag,
  output logic        last_out,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [63:0] cfg_data
);

  xsc_pkg::cmd_t  cmd;
  xsc_pkg::stat_t stat;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  xsc_ctrl #(
    .TAG_BYTES(TAG_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  xsc_datapath #(
    .KEY_BYTES(KEY_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .cmd      (cmd),
    .stat     (stat),
    .out_byte (out_byte),
    .is_tag   (is_tag),
    .last_out (last_out)
  );

endmodule

`default_nettype wire

/* hw/rtl/xsc_datapath.sv */
`default_nettype none

module xsc_datapath #(
  parameter int KEY_BYTES = xsc_pkg::KEY_BYTES_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_valid,
  input  wire  [2:0]          cfg_index,
  input  wire  [63:0]         cfg_data,
  input  wire  [7:0]          data_byte,
  input  wire                 last_byte,
  input  xsc_pkg::cmd_t       cmd,
  output xsc_pkg::stat_t      stat,
  output logic [7:0]          out_byte,
  output logic                is_tag,
  output logic                last_out
);

  // configuration registers
  logic        mode_decrypt;
  logic [5:0]  key_count;
  logic [63:0] key_word0, key_word1, key_word2, key_word3;
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;

  // running state
  logic [31:0] hash_a, hash_b;
  logic [4:0]  key_position;
  logic [3:0]  nonce_position;
  logic [2:0]  rotate_position;

  // latched input transaction
  logic [7:0]  din;
  logic        last_in;

  logic [255:0] key_all;
  logic [127:0] nonce_all;
  logic [5:0]   klen;

  logic [7:0]  msg_kb, msg_nb, msg_dout, msg_hin;
  logic [7:0]  abs_nb, abs_kb;
  logic [8:0]  abs_nsum;
  logic [1:0]  sel_a, sel_b;
  logic [7:0]  tag_byte;

  assign key_all   = {key_word3, key_word2, key_word1, key_word0};
  assign nonce_all = {32'd0, nonce_high, nonce_low};

  // effective key length, clamped to 1..KEY_BYTES
  always_comb begin
    if (key_count == 6'd0) begin
      klen = 6'd1;
    end else if (key_count > 6'(KEY_BYTES)) begin
      klen = 6'(KEY_BYTES);
    end else begin
      klen = key_count;
    end
  end

  // message byte transform
  assign msg_kb   = key_all[{key_position, 3'b000} +: 8];
  assign msg_nb   = nonce_all[{nonce_position, 3'b000} +: 8];
  assign msg_dout = din ^ msg_kb ^ msg_nb;
  assign msg_hin  = mode_decrypt ? din : msg_dout;

  // absorb bytes
  assign abs_nb   = nonce_all[{cmd.idx[3:0], 3'b000} +: 8];
  assign abs_kb   = key_all[{cmd.idx, 3'b000} +: 8];
  assign abs_nsum = {1'b0, abs_nb} + {5'd0, cmd.idx[3:0]};

  // tag byte from both hashes
  assign sel_a    = cmd.idx[1:0];
  assign sel_b    = cmd.idx[1:0] + 2'd1;
  assign tag_byte = hash_a[{sel_a, 3'b000} +: 8] ^ hash_b[{sel_b, 3'b000} +: 8];

  assign stat.last     = last_in;
  assign stat.key_done = ({1'b0, cmd.idx} + 6'd1) >= klen;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_decrypt <= 1'b0;
      key_count    <= 6'd1;
      key_word0    <= '0;
      key_word1    <= '0;
      key_word2    <= '0;
      key_word3    <= '0;
      nonce_low    <= '0;
      nonce_high   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        xsc_pkg::CFG_MODE:       mode_decrypt <= cfg_data[0];
        xsc_pkg::CFG_KEY_COUNT:  key_count    <= cfg_data[5:0];
        xsc_pkg::CFG_KEY_WORD0:  key_word0    <= cfg_data;
        xsc_pkg::CFG_KEY_WORD1:  key_word1    <= cfg_data;
        xsc_pkg::CFG_KEY_WORD2:  key_word2    <= cfg_data;
        xsc_pkg::CFG_KEY_WORD3:  key_word3    <= cfg_data;
        xsc_pkg::CFG_NONCE_LOW:  nonce_low    <= cfg_data;
        xsc_pkg::CFG_NONCE_HIGH: nonce_high   <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // hash and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_a          <= xsc_pkg::HA_INIT;
      hash_b          <= xsc_pkg::HB_INIT;
      key_position    <= '0;
      nonce_position  <= '0;
      rotate_position <= '0;
    end else begin
      case (cmd.op)
        xsc_pkg::OP_MSG: begin
          hash_a <= (hash_a ^ {24'd0, msg_hin}) * xsc_pkg::MUL_A;
          hash_b <= (hash_b ^ {24'd0, xsc_pkg::rot8(msg_hin, rotate_position + 3'd1)})
                    * xsc_pkg::MUL_MSG;
          key_position <= (({1'b0, key_position} + 6'd1) >= klen) ? 5'd0
                          : key_position + 5'd1;
          nonce_position <= (({1'b0, nonce_position} + 5'd1) >= 5'(xsc_pkg::NONCE_BYTES))
                            ? 4'd0 : nonce_position + 4'd1;
          rotate_position <= (rotate_position >= 3'd6) ? 3'd0 : rotate_position + 3'd1;
        end
        xsc_pkg::OP_NONCE: begin
          hash_a <= (hash_a ^ {24'd0, abs_nb}) * xsc_pkg::MUL_A;
          hash_b <= (hash_b ^ {23'd0, abs_nsum}) * xsc_pkg::MUL_NONCE;
        end
        xsc_pkg::OP_KEY: begin
          hash_a <= (hash_a ^ {24'd0, abs_kb}) * xsc_pkg::MUL_A;
          hash_b <= (hash_b ^ {24'd0, xsc_pkg::rot8(abs_kb, cmd.rot + 3'd1)})
                    * xsc_pkg::MUL_KEY;
        end
        xsc_pkg::OP_TAG: begin
          // reload for the next message after the final tag byte
          if (cmd.final_tag) begin
            hash_a          <= xsc_pkg::HA_INIT;
            hash_b          <= xsc_pkg::HB_INIT;
            key_position    <= '0;
            nonce_position  <= '0;
            rotate_position <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // input latch and output payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      xsc_pkg::OP_LOAD: begin
        din     <= data_byte;
        last_in <= last_byte;
      end
      xsc_pkg::OP_MSG: begin
        out_byte <= msg_dout;
        is_tag   <= 1'b0;
        last_out <= 1'b0;
      end
      xsc_pkg::OP_TAG: begin
        out_byte <= tag_byte;
        is_tag   <= 1'b1;
        last_out <= cmd.final_tag;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/xsc_ctrl.sv */
`default_nettype none

module xsc_ctrl #(
  parameter int TAG_BYTES = xsc_pkg::TAG_BYTES_DEFAULT
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  input  xsc_pkg::stat_t  stat,
  output xsc_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MSG,
    S_NONCE,
    S_KEY,
    S_TAG
  } state_t;

  state_t                    state;
  logic [xsc_pkg::IDX_W-1:0] cnt;
  logic [2:0]                rot5;
  logic                      out_free;
  logic                      load_out;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign load_out = (cmd.op == xsc_pkg::OP_MSG) || (cmd.op == xsc_pkg::OP_TAG);

  // command decode
  always_comb begin
    cmd.op        = xsc_pkg::OP_NOP;
    cmd.idx       = cnt;
    cmd.rot       = rot5;
    cmd.final_tag = (cnt == xsc_pkg::IDX_W'(TAG_BYTES - 1));
    case (state)
      S_IDLE:  if (in_valid) cmd.op = xsc_pkg::OP_LOAD;
      S_MSG:   if (out_free) cmd.op = xsc_pkg::OP_MSG;
      S_NONCE: cmd.op = xsc_pkg::OP_NONCE;
      S_KEY:   cmd.op = xsc_pkg::OP_KEY;
      S_TAG:   if (out_free) cmd.op = xsc_pkg::OP_TAG;
      default: cmd.op = xsc_pkg::OP_NOP;
    endcase
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rot5      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MSG;
        end
        S_MSG: begin
          if (out_free) begin
            cnt   <= '0;
            state <= stat.last ? S_NONCE : S_IDLE;
          end
        end
        S_NONCE: begin
          if (cnt == xsc_pkg::IDX_W'(xsc_pkg::NONCE_BYTES - 1)) begin
            cnt   <= '0;
            rot5  <= '0;
            state <= S_KEY;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_KEY: begin
          if (stat.key_done) begin
            cnt   <= '0;
            state <= S_TAG;
          end else begin
            cnt  <= cnt + 1'b1;
            rot5 <= (rot5 >= 3'd4) ? 3'd0 : rot5 + 3'd1;
          end
        end
        S_TAG: begin
          if (out_free) begin
            if (cmd.final_tag) begin
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register is only loaded when it can take a new transaction
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || !out_stall))
    else $error("output loaded while a transaction is pending");

  // an accepted input moves straight to the message step
  a_accept_to_msg: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MSG))
    else $error("accepted input did not start the message step");

  // key absorb ends in the tag phase at the first tag byte
  a_key_to_tag: assert property (@(posedge clk) disable iff (rst)
    (state == S_KEY && stat.key_done) |=> (state == S_TAG && cnt == '0))
    else $error("key absorb did not hand over to tag output");

  // nonce index stays inside the nonce
  a_nonce_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_NONCE) |-> (cnt < xsc_pkg::IDX_W'(xsc_pkg::NONCE_BYTES)))
    else $error("nonce index out of range");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
module tb_top;

  localparam int TAG_LEN       = xsc_pkg::TAG_BYTES_DEFAULT;
  localparam int KEY_MAX       = xsc_pkg::KEY_BYTES_DEFAULT;
  localparam int SETTLE_CYCLES = 2 + xsc_pkg::NONCE_BYTES + KEY_MAX + TAG_LEN;
  localparam int QUIET_LIMIT   = 2000;
  localparam int CHUNK_ITEMS   = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  typedef struct packed {
    logic [7:0] value;
    logic       tag;
    logic       final_tag;
  } cipher_out_t;

  // dut ports
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        is_tag;
  logic        last_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = xsc_pkg::CFG_MODE;
  logic [63:0] cfg_data  = 64'h0;

  // stimulus and scoreboard
  msg_byte_t   pending_bytes[$];
  cipher_out_t expected_bytes[$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fail_count    = 0;
  int          quiet_cycles  = 0;

  // predictor copy of configuration and state
  logic        cfg_decrypt;
  logic [5:0]  cfg_key_len;
  logic [63:0] cfg_key [4];
  logic [63:0] cfg_nonce_lo;
  logic [31:0] cfg_nonce_hi;
  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [4:0]  key_pos;
  logic [3:0]  nonce_pos;
  logic [2:0]  rot_pos;

  xor_stream_cipher_with_tag_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_tag    (is_tag),
    .last_out  (last_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] key_at(input logic [4:0] i);
    return cfg_key[i[4:3]][i[2:0]*8 +: 8];
  endfunction

  // nonce slots past the last nonce byte read as zero
  function automatic logic [7:0] nonce_at(input logic [3:0] i);
    if (i < 4'd8) begin
      return cfg_nonce_lo[i[2:0]*8 +: 8];
    end else if (i < 4'd12) begin
      return cfg_nonce_hi[i[1:0]*8 +: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int s);
    logic [31:0] w;
    w = {24'h0, v};
    w = (w << s) | (w >> (8 - s));
    return w[7:0];
  endfunction

  // zero counts as one, anything past the key size saturates
  function automatic int key_len_eff();
    if (cfg_key_len == 6'd0) return 1;
    if (int'(cfg_key_len) > KEY_MAX) return KEY_MAX;
    return int'(cfg_key_len);
  endfunction

  function automatic void reload_hashes();
    hash_a    = xsc_pkg::HA_INIT;
    hash_b    = xsc_pkg::HB_INIT;
    key_pos   = 5'd0;
    nonce_pos = 4'd0;
    rot_pos   = 3'd0;
  endfunction

  // cipher one byte, and on the last byte absorb nonce and key and emit the tag
  function automatic void predict_cipher(input logic [7:0] din, input logic last);
    logic [7:0]  dout;
    logic [7:0]  hin;
    logic [7:0]  b;
    logic [31:0] t;
    int          klen;
    klen = key_len_eff();
    dout = din ^ key_at(key_pos) ^ nonce_at(nonce_pos);
    hin  = cfg_decrypt ? din : dout;
    hash_a = (hash_a ^ {24'h0, hin}) * xsc_pkg::MUL_A;
    hash_b = (hash_b ^ {24'h0, rotl8(hin, int'(rot_pos) + 1)}) * xsc_pkg::MUL_MSG;
    key_pos   = (int'(key_pos) + 1 >= klen) ? 5'd0 : key_pos + 5'd1;
    nonce_pos = (int'(nonce_pos) + 1 >= xsc_pkg::NONCE_BYTES) ? 4'd0 : nonce_pos + 4'd1;
    rot_pos   = (int'(rot_pos) + 1 >= 7) ? 3'd0 : rot_pos + 3'd1;
    expected_bytes.push_back('{dout, 1'b0, 1'b0});
    if (!last) return;
    for (int i = 0; i < xsc_pkg::NONCE_BYTES; i++) begin
      b = nonce_at(i[3:0]);
      hash_a = (hash_a ^ {24'h0, b}) * xsc_pkg::MUL_A;
      hash_b = (hash_b ^ ((32'(b) + 32'(i)) & 32'h1FF)) * xsc_pkg::MUL_NONCE;
    end
    for (int i = 0; i < klen; i++) begin
      b = key_at(i[4:0]);
      hash_a = (hash_a ^ {24'h0, b}) * xsc_pkg::MUL_A;
      hash_b = (hash_b ^ {24'h0, rotl8(b, (i % 5) + 1)}) * xsc_pkg::MUL_KEY;
    end
    for (int i = 0; i < TAG_LEN; i++) begin
      t = (hash_a >> (8 * (i % 4))) ^ (hash_b >> (8 * ((i + 1) % 4)));
      expected_bytes.push_back('{t[7:0], 1'b1, (i == TAG_LEN - 1)});
    end
    reload_hashes();
  endfunction

  // one register write transaction, mirrored into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      xsc_pkg::CFG_MODE:       cfg_decrypt  = value[0];
      xsc_pkg::CFG_KEY_COUNT:  cfg_key_len  = value[5:0];
      xsc_pkg::CFG_KEY_WORD0:  cfg_key[0]   = value;
      xsc_pkg::CFG_KEY_WORD1:  cfg_key[1]   = value;
      xsc_pkg::CFG_KEY_WORD2:  cfg_key[2]   = value;
      xsc_pkg::CFG_KEY_WORD3:  cfg_key[3]   = value;
      xsc_pkg::CFG_NONCE_LOW:  cfg_nonce_lo = value;
      xsc_pkg::CFG_NONCE_HIGH: cfg_nonce_hi = value[31:0];
      default: ;
    endcase
  endtask

  task automatic program_config(input logic decrypt, input logic [5:0] klen,
                                input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] nlo, input logic [31:0] nhi);
    write_reg(xsc_pkg::CFG_MODE, {63'h0, decrypt});
    write_reg(xsc_pkg::CFG_KEY_COUNT, {58'h0, klen});
    write_reg(xsc_pkg::CFG_KEY_WORD0, k0);
    write_reg(xsc_pkg::CFG_KEY_WORD1, k1);
    write_reg(xsc_pkg::CFG_KEY_WORD2, k2);
    write_reg(xsc_pkg::CFG_KEY_WORD3, k3);
    write_reg(xsc_pkg::CFG_NONCE_LOW, nlo);
    write_reg(xsc_pkg::CFG_NONCE_HIGH, {32'h0, nhi});
  endtask

  function automatic void queue_byte(input logic [7:0] data, input logic last);
    pending_bytes.push_back('{data, last});
  endfunction

  // hold off until every queued byte went in and every result came out
  task automatic drain();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [5:0] pick_key_len();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'($urandom_range(33, 63));
      2: return 6'd32;
      3: return 6'd1;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin : drive_input
    msg_byte_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_cipher(data_byte, last_byte);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item = pending_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= item.data;
          last_byte <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stall
  always @(posedge clk) begin : watch_output
    cipher_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected output transaction: out_byte %02h is_tag %0b last_out %0b",
                 out_byte, is_tag, last_out);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, out_byte);
            fail_count++;
          end
          if (is_tag !== want.tag) begin
            $error("is_tag: expected %0b, got %0b", want.tag, is_tag);
            fail_count++;
          end
          if (last_out !== want.final_tag) begin
            $error("last_out: expected %0b, got %0b", want.final_tag, last_out);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int chunk_items;
    int len;
    cfg_decrypt  = 1'b0;
    cfg_key_len  = 6'd1;
    cfg_key[0]   = 64'h0;
    cfg_key[1]   = 64'h0;
    cfg_key[2]   = 64'h0;
    cfg_key[3]   = 64'h0;
    cfg_nonce_lo = 64'h0;
    cfg_nonce_hi = 32'h0;
    reload_hashes();
    send_idle_pct = 31;
    recv_idle_pct = 54;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // short key, all-ones nonce so the nonce sum needs the ninth bit
    program_config(1'b0, 6'd3, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, '1, '1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hFF, 1'b1);
    drain();

    // decrypt, zero key length, all-ones key, zero nonce
    program_config(1'b1, 6'd0, '1, '1, '1, '1, 64'h0, 32'h0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'hAA, 1'b1);
    drain();

    // oversize key length, then lowered below the key position mid-message
    program_config(1'b0, 6'd63, pick_word(), pick_word(), pick_word(), pick_word(),
                   pick_word(), $urandom);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b0);
    drain();
    write_reg(xsc_pkg::CFG_KEY_COUNT, 64'd2);
    queue_byte(8'h9A, 1'b0);
    queue_byte(8'hBC, 1'b1);
    drain();

    // full key, decrypt, message long enough to wrap the nonce
    program_config(1'b1, 6'd32, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   $urandom);
    for (int i = 0; i < 13; i++) queue_byte(8'(i * 19), i == 12);
    drain();

    // random messages under three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 31; recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 31; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int c = 0; c < 3; c++) begin
        program_config(1'($urandom), pick_key_len(), pick_word(), pick_word(),
                       pick_word(), pick_word(), pick_word(), 32'(pick_word()));
        chunk_items = 0;
        while (chunk_items < CHUNK_ITEMS) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          // the final message of a chunk is sometimes left open across a reconfig
          for (int i = 0; i < len; i++) begin
            queue_byte(8'($urandom),
                       (i == len - 1) &&
                       (chunk_items + len < CHUNK_ITEMS || $urandom_range(0, 3) != 0));
          end
          chunk_items += len;
        end
        drain();
      end
    end

    fail_count += expected_bytes.size();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
